>>> rtl/bet_pkg.sv
// shared types and constants for the block entropy term accumulator
package bet_pkg;

    localparam int LOG_FB = 24;
    localparam int LN_FB = 54;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = 2;
    localparam int LOG_BITS = 5 + LOG_FB;
    localparam int LN_MAG_BITS = 62;
    localparam int PROD_BITS = 32 + LN_MAG_BITS;

    typedef struct packed {
        logic [15:0] entry_index;
        logic [31:0] entry_weight;
        logic [31:0] entry_block_degree;
        logic [31:0] query_degree;
        logic [15:0] exclude_first;
        logic [15:0] exclude_second;
        logic        use_exclusion;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] entropy_term;
        logic               zero_degree_seen;
    } t_out_item;

    // classified entry handed from the front end to the engine
    typedef struct packed {
        logic [31:0] w;
        logic [31:0] bd;
        logic [31:0] deg;
        logic        skip;
        logic        zero_deg;
        logic        last;
    } t_work;

endpackage

>>> rtl/block_entropy_term_accumulator.sv
// top level of the block entropy term accumulator
//
//   channel   | handshake              | payload
//   ----------+------------------------+---------------------------
//   input     | push / full            | i_in_item  (t_in_item)
//   result    | pop / empty            | o_out_item (t_out_item)
//   config    | i_cfg_we               | i_cfg_data (undirected_mode)
//
// a computed entry goes through one queue read, 24 squaring steps in the
// three parallel log2 lanes, then difference, scale, two partial products,
// saturate, add and a final emit state. skipped and zero-degree entries go
// from the queue read straight to the emit state. a 4-entry queue lets push
// continue while the engine works; a waiting result only stalls the engine
// on the next last entry. reset is synchronous and clears sum, flag, queue and mode.
module block_entropy_term_accumulator
    import bet_pkg::*;
#(
    parameter int WEIGHT_BITS = 32,
    parameter int FRAC_BITS = 12,
    parameter int INDEX_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    logic  r_undirected;
    logic  q_valid, q_pop;
    t_work q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undirected <= 1'b0;
        end else if (i_cfg_we) begin
            r_undirected <= i_cfg_data;
        end
    end

    bet_front #(
        .WEIGHT_BITS(WEIGHT_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_in_item,
        .o_q_valid(q_valid), .o_q_work(q_work), .i_q_pop(q_pop)
    );

    bet_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_undirected(r_undirected),
        .i_q_valid(q_valid), .i_q_work(q_work), .o_q_pop(q_pop),
        .empty, .pop, .o_out_item
    );

endmodule

>>> rtl/bet_front.sv
// front end: masks and classifies entries, holds them in a short queue
module bet_front
    import bet_pkg::*;
#(
    parameter int WEIGHT_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_in_item,
    output logic     o_q_valid,
    output t_work    o_q_work,
    input  logic     i_q_pop
);

    localparam int WB = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
    localparam int IB = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam logic [32:0] WMASK_W = (33'd1 << WB) - 33'd1;
    localparam logic [31:0] WMASK = WMASK_W[31:0];

    t_work                r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    t_work       n_work;
    logic        wr_en, rd_en, excluded;
    logic [31:0] w_m;

    assign w_m = i_in_item.entry_weight & WMASK;
    assign excluded = i_in_item.use_exclusion &&
        ((i_in_item.entry_index[IB-1:0] == i_in_item.exclude_first[IB-1:0]) ||
         (i_in_item.entry_index[IB-1:0] == i_in_item.exclude_second[IB-1:0]));

    always_comb begin
        n_work.w        = w_m;
        n_work.bd       = i_in_item.entry_block_degree & WMASK;
        n_work.deg      = i_in_item.query_degree & WMASK;
        n_work.skip     = (w_m == 32'd0) || excluded;
        n_work.zero_deg = (n_work.bd == 32'd0) || (n_work.deg == 32'd0);
        n_work.last     = i_in_item.last;
    end

    assign full      = (r_count == (QPTR_BITS+1)'(QDEPTH));
    assign wr_en     = push && !full;
    assign o_q_valid = (r_count != '0);
    assign rd_en     = i_q_pop && o_q_valid;
    assign o_q_work  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= n_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd_en) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (QPTR_BITS+1)'(wr_en) - (QPTR_BITS+1)'(rd_en);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_BITS+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != (QPTR_BITS+1)'(QDEPTH)) |->
            (QPTR_BITS'(r_wr_ptr - r_rd_ptr) == r_count[QPTR_BITS-1:0]))
        else $error("queue pointers disagree with count");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !rd_en) |=> full)
        else $error("full queue changed with no read");

endmodule

>>> rtl/bet_log2.sv
// one log2 lane: normalize, then one fraction bit per squaring step
module bet_log2
    import bet_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_load,
    input  logic                i_step,
    input  logic [31:0]         i_x,
    output logic [LOG_BITS-1:0] o_log
);

    logic [4:0]        r_p;
    logic [31:0]       r_m;
    logic [LOG_FB-1:0] r_frac;

    logic [4:0]  p;
    logic [63:0] sq;
    logic [32:0] t;

    always_comb begin
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) p = 5'(i);
        end
    end

    assign sq = r_m * r_m;
    assign t  = sq[63:31];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p    <= p;
            r_m    <= i_x << (5'd31 - p);
            r_frac <= '0;
        end else if (i_step) begin
            r_m    <= t[32] ? t[32:1] : t[31:0];
            r_frac <= {r_frac[LOG_FB-2:0], t[32]};
        end
    end

    assign o_log = {r_p, r_frac};

endmodule

>>> rtl/bet_back.sv
// engine: three log lanes, ln2 scaling, split product, saturating accumulate
module bet_back
    import bet_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_undirected,
    input  logic      i_q_valid,
    input  t_work     i_q_work,
    output logic      o_q_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    localparam int SH = LN_FB - FRAC_BITS;
    localparam logic signed [31:0] ONE_LOG = 32'sd1 <<< LOG_FB;
    localparam logic signed [31:0] LN2_S = $signed({2'b00, LN2_Q30});
    localparam logic [63:0] POS_CAP = {1'b0, {63{1'b1}}};
    localparam logic [63:0] NEG_CAP = {1'b1, 63'd0};

    typedef enum logic [3:0] {
        S_IDLE, S_LOG, S_DIFF, S_LN, S_P0, S_P1, S_SAT, S_ADD, S_EMIT
    } t_state;

    t_state                  r_state;
    t_work                   r_work;
    logic [4:0]              r_cnt;
    logic signed [31:0]      r_d;
    logic [LN_MAG_BITS-1:0]  r_lnmag;
    logic                    r_neg;
    logic [PROD_BITS-1:0]    r_prod;
    logic signed [63:0]      r_term;
    logic signed [63:0]      r_sum;
    logic                    r_err;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                   load, step, out_free, emit;
    logic [LOG_BITS-1:0]    lw, lb, lg;
    logic signed [63:0]     lnv;
    logic [63:0]            lnabs;
    logic [62:0]            pp_lo, pp_hi;
    logic [PROD_BITS-1:0]   shifted;
    logic                   ovf;
    logic [63:0]            mag;
    logic signed [64:0]     sum_x;
    logic signed [63:0]     sum_sat;

    assign o_q_pop = (r_state == S_IDLE);
    assign load    = (r_state == S_IDLE) && i_q_valid;
    assign step    = (r_state == S_LOG);

    bet_log2 u_log_w (.i_clk, .i_load(load), .i_step(step), .i_x(i_q_work.w),   .o_log(lw));
    bet_log2 u_log_b (.i_clk, .i_load(load), .i_step(step), .i_x(i_q_work.bd),  .o_log(lb));
    bet_log2 u_log_g (.i_clk, .i_load(load), .i_step(step), .i_x(i_q_work.deg), .o_log(lg));

    assign lnv   = r_d * LN2_S;
    assign lnabs = lnv[63] ? 64'(-lnv) : 64'(lnv);

    // two 32x31 partial products of weight and ln magnitude
    assign pp_lo = r_work.w * r_lnmag[30:0];
    assign pp_hi = r_work.w * r_lnmag[LN_MAG_BITS-1:31];

    always_comb begin
        shifted = i_undirected ? (r_prod >> (SH + 1)) : (r_prod >> SH);
        if (r_neg) begin
            ovf = (|shifted[PROD_BITS-1:64]) || (shifted[63:0] > NEG_CAP);
            mag = ovf ? NEG_CAP : shifted[63:0];
        end else begin
            ovf = (|shifted[PROD_BITS-1:64]) || shifted[63];
            mag = ovf ? POS_CAP : shifted[63:0];
        end
    end

    assign sum_x = {r_sum[63], r_sum} + {r_term[63], r_term};
    always_comb begin
        if (sum_x[64] != sum_x[63]) begin
            sum_sat = sum_x[64] ? $signed(NEG_CAP) : $signed(POS_CAP);
        end else begin
            sum_sat = sum_x[63:0];
        end
    end

    assign out_free = !r_out_valid || pop;
    assign emit     = (r_state == S_EMIT) && r_work.last && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) r_out_valid <= 1'b1;
            else if (pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_work <= i_q_work;
                        r_cnt  <= '0;
                        if (i_q_work.skip) begin
                            r_state <= S_EMIT;
                        end else if (i_q_work.zero_deg) begin
                            r_err   <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_LOG;
                        end
                    end
                end
                S_LOG: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(LOG_FB - 1)) r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_d <= $signed({3'b000, lw}) - $signed({3'b000, lb})
                         - $signed({3'b000, lg}) + (i_undirected ? ONE_LOG : 32'sd0);
                    r_state <= S_LN;
                end
                S_LN: begin
                    r_neg   <= lnv[63];
                    r_lnmag <= lnabs[LN_MAG_BITS-1:0];
                    r_state <= S_P0;
                end
                S_P0: begin
                    r_prod  <= PROD_BITS'(pp_lo);
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_prod  <= r_prod + (PROD_BITS'(pp_hi) << 31);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_term  <= r_neg ? $signed(64'(-mag)) : $signed(mag);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum   <= sum_sat;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_work.last) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out.entropy_term     <= r_sum;
                        r_out.zero_degree_seen <= r_err;
                        r_sum                  <= '0;
                        r_err                  <= 1'b0;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    a_log_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOG) |-> (r_cnt <= 5'(LOG_FB - 1)))
        else $error("log step count overrun");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_work.last && out_free) |=> (r_sum == '0 && !r_err))
        else $error("accumulator not cleared after result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_work.last && r_out_valid && !pop) |=> (r_state == S_EMIT))
        else $error("result written over a waiting one");

endmodule
